// ----- hdl/ecpr_pkg.sv -----
`default_nettype none

package ecpr_pkg;

   // Fixed field widths of the request and result items
   localparam int OPERATION_W = 2;
   localparam int PROCESS_W   = 2;
   localparam int PAGE_W      = 6;
   localparam int SET_SIZE_W  = 5;
   localparam int STATUS_W    = 2;

   // Default sizing of the tables
   localparam int DEF_PROCESSES = 4;
   localparam int DEF_PAGES     = 64;
   localparam int DEF_FRAMES    = 16;

   // Operation codes
   localparam logic [OPERATION_W-1:0] OP_INIT    = 2'd0;
   localparam logic [OPERATION_W-1:0] OP_TOUCH   = 2'd1;
   localparam logic [OPERATION_W-1:0] OP_REPLACE = 2'd2;

   // Status codes
   localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] ST_MISS  = 2'd1;
   localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

   // Controller to datapath
   typedef struct packed {
      logic latch_req;
      logic clr_step;
      logic init_step;
      logic touch_wr;
      logic set_miss;
      logic set_empty;
      logic scan_load;
      logic scan_step;
      logic commit;
      logic map_clr;
      logic map_set;
      logic rsp_load;
   } ecpr_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic clr_last;
      logic init_last;
      logic op_init;
      logic op_touch;
      logic op_replace;
      logic proc_ok;
      logic page_ok;
      logic set_empty;
      logic map_valid;
      logic scan_hit;
   } ecpr_stat_type;

endpackage

`default_nettype wire

// ----- hdl/ecpr_req_if.sv -----
`default_nettype none

interface ecpr_req_if import ecpr_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic [OPERATION_W-1:0] operation;
   logic [PROCESS_W-1:0]   process;
   logic [PAGE_W-1:0]      page;
   logic                   dirty_in;
   logic [SET_SIZE_W-1:0]  set_size;

   modport source (
      output valid, operation, process, page, dirty_in, set_size,
      input  ready
   );

   modport sink (
      input  valid, operation, process, page, dirty_in, set_size,
      output ready
   );
endinterface

`default_nettype wire

// ----- hdl/ecpr_rsp_if.sv -----
`default_nettype none

interface ecpr_rsp_if import ecpr_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [PAGE_W-1:0]   victim_page;
   logic                victim_dirty;
   logic [STATUS_W-1:0] status;

   modport source (
      output valid, victim_page, victim_dirty, status,
      input  ready
   );

   modport sink (
      input  valid, victim_page, victim_dirty, status,
      output ready
   );
endinterface

`default_nettype wire

// ----- hdl/ecpr_ctrl.sv -----
`default_nettype none

module ecpr_ctrl import ecpr_pkg::*; (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_valid,
   output logic               req_ready,
   output logic               rsp_valid,
   input  wire logic          rsp_ready,
   input  wire ecpr_stat_type stat,
   output ecpr_cmd_type       cmd
);

   typedef enum logic [3:0] {
      S_CLEAR,
      S_IDLE,
      S_DECODE,
      S_INIT,
      S_TOUCH,
      S_SCAN,
      S_COMMIT,
      S_MAP_CLR,
      S_MAP_SET,
      S_FINISH
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      cmd          = '0;
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      case (state_ff)
         S_CLEAR: begin
            cmd.clr_step = 1'b1;
            if (stat.clr_last) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req_valid) begin
               cmd.latch_req = 1'b1;
               state_in      = S_DECODE;
            end
         end
         S_DECODE: begin
            if (stat.op_init) begin
               state_in = stat.proc_ok ? S_INIT : S_FINISH;
            end else if (stat.op_touch) begin
               if (stat.proc_ok && stat.page_ok) begin
                  state_in = S_TOUCH;
               end else begin
                  cmd.set_miss = 1'b1;
                  state_in     = S_FINISH;
               end
            end else if (stat.op_replace) begin
               if (stat.set_empty) begin
                  cmd.set_empty = 1'b1;
                  state_in      = S_FINISH;
               end else if (!stat.page_ok) begin
                  cmd.set_miss = 1'b1;
                  state_in     = S_FINISH;
               end else begin
                  cmd.scan_load = 1'b1;
                  state_in      = S_SCAN;
               end
            end else begin
               state_in = S_FINISH;
            end
         end
         S_INIT: begin
            cmd.init_step = 1'b1;
            if (stat.init_last) state_in = S_FINISH;
         end
         S_TOUCH: begin
            if (stat.map_valid) cmd.touch_wr = 1'b1;
            else cmd.set_miss = 1'b1;
            state_in = S_FINISH;
         end
         S_SCAN: begin
            cmd.scan_step = 1'b1;
            if (stat.scan_hit) state_in = S_COMMIT;
         end
         S_COMMIT: begin
            cmd.commit = 1'b1;
            state_in   = S_MAP_CLR;
         end
         S_MAP_CLR: begin
            cmd.map_clr = 1'b1;
            state_in    = S_MAP_SET;
         end
         S_MAP_SET: begin
            cmd.map_set = 1'b1;
            state_in    = S_FINISH;
         end
         S_FINISH: begin
            // wait for the output register to drain
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.rsp_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

// ----- hdl/ecpr_dp.sv -----
`default_nettype none

module ecpr_dp import ecpr_pkg::*; #(
   parameter int PROCESSES = DEF_PROCESSES,
   parameter int PAGES     = DEF_PAGES,
   parameter int FRAMES    = DEF_FRAMES
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic [OPERATION_W-1:0] operation,
   input  wire logic [PROCESS_W-1:0]   process,
   input  wire logic [PAGE_W-1:0]      page,
   input  wire logic                   dirty_in,
   input  wire logic [SET_SIZE_W-1:0]  set_size,
   input  wire ecpr_cmd_type           cmd,
   output ecpr_stat_type               stat,
   output logic [PAGE_W-1:0]           victim_page,
   output logic                        victim_dirty,
   output logic [STATUS_W-1:0]         status
);

   localparam int PIX_W     = (PROCESSES > 1) ? $clog2(PROCESSES) : 1;
   localparam int PG_W      = $clog2(PAGES);
   localparam int FI_W      = (FRAMES > 1) ? $clog2(FRAMES) : 1;
   localparam int LIM       = (FRAMES < PAGES) ? FRAMES : PAGES;
   localparam int CNT_W     = $clog2(LIM + 1);
   localparam int SPG_W     = ($clog2(LIM) > PAGE_W) ? $clog2(LIM) : PAGE_W;
   localparam int MAP_AW    = PIX_W + PG_W;
   localparam int FR_AW     = PIX_W + FI_W;
   localparam int MAP_W     = FI_W + 1;
   localparam int MAP_DEPTH = 1 << MAP_AW;
   localparam int FR_DEPTH  = 1 << FR_AW;

   // latched request
   logic [OPERATION_W-1:0] op_ff;
   logic [PIX_W-1:0]       pidx_ff;
   logic                   proc_ok_ff;
   logic [PAGE_W-1:0]      page_ff;
   logic                   page_ok_ff;
   logic                   din_ff;
   logic [CNT_W-1:0]       size_ff;

   // per-process state
   logic [CNT_W-1:0] fis_ff  [PROCESSES];
   logic [FI_W-1:0]  hand_ff [PROCESSES];

   logic [MAP_AW-1:0] clr_ff;
   logic [PG_W-1:0]   init_i_ff;

   // scan issue and evaluate stages
   logic [FI_W-1:0]  iss_hand_ff;
   logic [CNT_W-1:0] iss_k_ff;
   logic [1:0]       iss_sw_ff;
   logic             iss_live_ff;
   logic             ev_valid_ff;
   logic [FI_W-1:0]  ev_hand_ff;
   logic [1:0]       ev_sw_ff;

   // chosen frame
   logic [FI_W-1:0]  vic_fi_ff;
   logic [SPG_W-1:0] vic_page_ff;
   logic             vic_dirty_ff;
   logic [FI_W-1:0]  next_hand_ff;

   logic [PAGE_W-1:0]   res_page_ff;
   logic                res_dirty_ff;
   logic [STATUS_W-1:0] res_status_ff;
   logic [PAGE_W-1:0]   out_page_ff;
   logic                out_dirty_ff;
   logic [STATUS_W-1:0] out_status_ff;

   // memories: flags are {used, dirty}
   logic [SPG_W-1:0] page_mem [FR_DEPTH];
   logic [1:0]       flag_mem [FR_DEPTH];
   logic [MAP_W-1:0] map_mem  [MAP_DEPTH];
   logic [SPG_W-1:0] page_rd_ff;
   logic [1:0]       flag_rd_ff;
   logic [MAP_W-1:0] map_rd_ff;

   logic [CNT_W-1:0]  cur_size;
   logic [PG_W-1:0]   pg_idx;
   logic [PG_W-1:0]   vic_idx;
   logic              vic_ok;
   logic              init_in_set;
   logic              init_last;
   logic              ev_used;
   logic              ev_dirty;
   logic              scan_hit;
   logic              scan_clear;
   logic [FI_W-1:0]   map_fi;
   logic              iss_k_last;

   logic              flag_we;
   logic              page_we;
   logic [FR_AW-1:0]  fr_wa;
   logic [FR_AW-1:0]  fr_ra;
   logic [1:0]        flag_wd;
   logic [SPG_W-1:0]  page_wd;
   logic              map_we;
   logic [MAP_AW-1:0] map_wa;
   logic [MAP_AW-1:0] map_ra;
   logic [MAP_W-1:0]  map_wd;

   function automatic logic [FI_W-1:0] wrap_next(input logic [FI_W-1:0]  h,
                                                 input logic [CNT_W-1:0] n);
      logic [FI_W-1:0] r;
      if (CNT_W'(h) + CNT_W'(1) == n) r = '0;
      else r = h + FI_W'(1);
      return r;
   endfunction

   assign cur_size    = fis_ff[pidx_ff];
   assign pg_idx      = PG_W'(page_ff);
   assign vic_idx     = PG_W'(vic_page_ff);
   assign vic_ok      = int'(vic_page_ff) < PAGES;
   assign init_in_set = int'(init_i_ff) < int'(size_ff);
   assign init_last   = (init_i_ff == PG_W'(PAGES - 1));
   assign ev_used     = flag_rd_ff[1];
   assign ev_dirty    = flag_rd_ff[0];
   // clean sweeps take an unused clean frame, dirty sweeps an unused dirty one
   assign scan_hit    = cmd.scan_step && ev_valid_ff && !ev_used && (ev_dirty == ev_sw_ff[0]);
   assign scan_clear  = cmd.scan_step && ev_valid_ff && ev_sw_ff[0] && !scan_hit;
   assign map_fi      = map_rd_ff[FI_W-1:0];
   assign iss_k_last  = (iss_k_ff + CNT_W'(1) == cur_size);

   always_comb begin
      stat.clr_last   = &clr_ff;
      stat.init_last  = init_last;
      stat.op_init    = (op_ff == OP_INIT);
      stat.op_touch   = (op_ff == OP_TOUCH);
      stat.op_replace = (op_ff == OP_REPLACE);
      stat.proc_ok    = proc_ok_ff;
      stat.page_ok    = page_ok_ff;
      stat.set_empty  = !proc_ok_ff || (cur_size == '0);
      stat.map_valid  = map_rd_ff[MAP_W-1];
      stat.scan_hit   = scan_hit;
   end

   // frame memory ports
   always_comb begin
      flag_we = 1'b0;
      page_we = 1'b0;
      fr_wa   = {pidx_ff, ev_hand_ff};
      flag_wd = {1'b0, ev_dirty};
      page_wd = SPG_W'(page_ff);
      if (cmd.init_step && init_in_set) begin
         flag_we = 1'b1;
         page_we = 1'b1;
         fr_wa   = {pidx_ff, FI_W'(init_i_ff)};
         flag_wd = 2'b00;
         page_wd = SPG_W'(init_i_ff);
      end
      if (cmd.touch_wr) begin
         flag_we = 1'b1;
         fr_wa   = {pidx_ff, map_fi};
         flag_wd = {1'b1, din_ff};
      end
      if (scan_clear) begin
         flag_we = 1'b1;
      end
      if (cmd.commit) begin
         flag_we = 1'b1;
         page_we = 1'b1;
         fr_wa   = {pidx_ff, vic_fi_ff};
         flag_wd = 2'b10;
      end
   end

   assign fr_ra = {pidx_ff, iss_hand_ff};

   // write-first on the flags, so a used bit cleared in the same cycle as the read is seen
   always_ff @(posedge clock) begin
      if (flag_we) flag_mem[fr_wa] <= flag_wd;
      if (page_we) page_mem[fr_wa] <= page_wd;
      if (flag_we && (fr_wa == fr_ra)) flag_rd_ff <= flag_wd;
      else flag_rd_ff <= flag_mem[fr_ra];
      page_rd_ff <= page_mem[fr_ra];
   end

   // page map ports
   always_comb begin
      map_we = 1'b0;
      map_wa = {pidx_ff, pg_idx};
      map_wd = '0;
      if (cmd.clr_step) begin
         map_we = 1'b1;
         map_wa = clr_ff;
      end
      if (cmd.init_step) begin
         map_we = 1'b1;
         map_wa = {pidx_ff, init_i_ff};
         map_wd = init_in_set ? {1'b1, FI_W'(init_i_ff)} : '0;
      end
      // drop the victim's mapping only if it still points at this frame
      if (cmd.map_clr && vic_ok && (map_rd_ff == {1'b1, vic_fi_ff})) begin
         map_we = 1'b1;
         map_wa = {pidx_ff, vic_idx};
      end
      if (cmd.map_set) begin
         map_we = 1'b1;
         map_wd = {1'b1, vic_fi_ff};
      end
   end

   assign map_ra = cmd.commit ? {pidx_ff, vic_idx} : {pidx_ff, pg_idx};

   always_ff @(posedge clock) begin
      if (map_we) map_mem[map_wa] <= map_wd;
      map_rd_ff <= map_mem[map_ra];
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff      <= '0;
         iss_live_ff <= 1'b0;
         ev_valid_ff <= 1'b0;
         for (int i = 0; i < PROCESSES; i++) begin
            fis_ff[i]  <= '0;
            hand_ff[i] <= '0;
         end
      end else begin
         if (cmd.clr_step) clr_ff <= clr_ff + MAP_AW'(1);
         if (cmd.init_step && init_last) begin
            fis_ff[pidx_ff]  <= size_ff;
            hand_ff[pidx_ff] <= '0;
         end
         if (cmd.commit) hand_ff[pidx_ff] <= next_hand_ff;
         if (cmd.scan_load) begin
            iss_live_ff <= 1'b1;
            ev_valid_ff <= 1'b0;
         end else if (cmd.scan_step) begin
            ev_valid_ff <= iss_live_ff;
            if (iss_live_ff && iss_k_last && (iss_sw_ff == 2'd3)) iss_live_ff <= 1'b0;
         end
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (cmd.latch_req) begin
         op_ff         <= operation;
         pidx_ff       <= PIX_W'(process);
         proc_ok_ff    <= int'(process) < PROCESSES;
         page_ff       <= page;
         page_ok_ff    <= int'(page) < PAGES;
         din_ff        <= dirty_in;
         size_ff       <= (int'(set_size) > LIM) ? CNT_W'(LIM) : CNT_W'(set_size);
         init_i_ff     <= '0;
         res_page_ff   <= '0;
         res_dirty_ff  <= 1'b0;
         res_status_ff <= ST_OK;
      end
      if (cmd.init_step) init_i_ff <= init_i_ff + PG_W'(1);
      if (cmd.set_miss) res_status_ff <= ST_MISS;
      if (cmd.set_empty) res_status_ff <= ST_EMPTY;
      if (cmd.scan_load) begin
         iss_hand_ff <= hand_ff[pidx_ff];
         iss_k_ff    <= '0;
         iss_sw_ff   <= 2'd0;
      end else if (cmd.scan_step && iss_live_ff) begin
         ev_hand_ff  <= iss_hand_ff;
         ev_sw_ff    <= iss_sw_ff;
         iss_hand_ff <= wrap_next(iss_hand_ff, cur_size);
         if (iss_k_last) begin
            iss_k_ff  <= '0;
            iss_sw_ff <= iss_sw_ff + 2'd1;
         end else begin
            iss_k_ff <= iss_k_ff + CNT_W'(1);
         end
      end
      if (scan_hit) begin
         vic_fi_ff    <= ev_hand_ff;
         vic_page_ff  <= page_rd_ff;
         vic_dirty_ff <= ev_dirty;
         next_hand_ff <= wrap_next(ev_hand_ff, cur_size);
      end
      if (cmd.commit) begin
         res_page_ff  <= PAGE_W'(vic_page_ff);
         res_dirty_ff <= vic_dirty_ff;
      end
      if (cmd.rsp_load) begin
         out_page_ff   <= res_page_ff;
         out_dirty_ff  <= res_dirty_ff;
         out_status_ff <= res_status_ff;
      end
   end

   assign victim_page  = out_page_ff;
   assign victim_dirty = out_dirty_ff;
   assign status       = out_status_ff;

endmodule

`default_nettype wire

// ----- hdl/enhanced_clock_page_replacer.sv -----
`default_nettype none

// Channel   Role     Handshake     Payload
// req_ch    sink     valid/ready   operation, process, page, dirty_in, set_size
// rsp_ch    source   valid/ready   victim_page, victim_dirty, status
//
// One request at a time, one response per request. A replace that finds a
// nonempty set and a valid page runs the clock scan, which reads one frame
// a cycle from the frame memory. After reset the page map is cleared, one
// entry a cycle, and req_ch.ready stays low meanwhile. The response sits in
// an output register: the next request is taken while it waits, and stalls
// only at its own completion.

module enhanced_clock_page_replacer import ecpr_pkg::*; #(
   parameter int PROCESSES = DEF_PROCESSES,
   parameter int PAGES     = DEF_PAGES,
   parameter int FRAMES    = DEF_FRAMES
) (
   input wire logic    clock,
   input wire logic    reset,
   ecpr_req_if.sink    req_ch,
   ecpr_rsp_if.source  rsp_ch
);

   ecpr_cmd_type  cmd;
   ecpr_stat_type stat;

   ecpr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   ecpr_dp #(
      .PROCESSES (PROCESSES),
      .PAGES     (PAGES),
      .FRAMES    (FRAMES)
   ) u_dp (
      .clock        (clock),
      .reset        (reset),
      .operation    (req_ch.operation),
      .process      (req_ch.process),
      .page         (req_ch.page),
      .dirty_in     (req_ch.dirty_in),
      .set_size     (req_ch.set_size),
      .cmd          (cmd),
      .stat         (stat),
      .victim_page  (rsp_ch.victim_page),
      .victim_dirty (rsp_ch.victim_dirty),
      .status       (rsp_ch.status)
   );

endmodule

`default_nettype wire

// ----- verif/enhanced_clock_page_replacer_tb.sv -----
`timescale 1ns / 100ps

module enhanced_clock_page_replacer_tb;
   import ecpr_pkg::*;

   localparam int FRAME_IDX_W = $clog2(DEF_FRAMES);
   localparam logic [OPERATION_W-1:0] OP_UNUSED = 2'd3;
   localparam int SET_LIMIT = (DEF_FRAMES < DEF_PAGES) ? DEF_FRAMES : DEF_PAGES;

   typedef struct {
      logic [OPERATION_W-1:0] operation;
      logic [PROCESS_W-1:0]   proc_id;
      logic [PAGE_W-1:0]      page;
      logic                   dirty_in;
      logic [SET_SIZE_W-1:0]  set_size;
   } page_req_type;

   typedef struct {
      logic [PAGE_W-1:0]   victim_page;
      logic                victim_dirty;
      logic [STATUS_W-1:0] status;
   } page_rsp_type;

   logic clock = 1'b0;
   logic reset;

   ecpr_req_if req_bus ();
   ecpr_rsp_if rsp_bus ();

   enhanced_clock_page_replacer u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_bus),
      .rsp_ch (rsp_bus)
   );

   always #5 clock = ~clock;

   // Shadow of the resident sets
   bit [PAGE_W-1:0]      frame_page  [DEF_PROCESSES][DEF_FRAMES];
   bit                   frame_used  [DEF_PROCESSES][DEF_FRAMES];
   bit                   frame_dirty [DEF_PROCESSES][DEF_FRAMES];
   bit                   map_valid   [DEF_PROCESSES][DEF_PAGES];
   bit [FRAME_IDX_W-1:0] map_frame   [DEF_PROCESSES][DEF_PAGES];
   bit [FRAME_IDX_W-1:0] clock_pos   [DEF_PROCESSES];
   bit [SET_SIZE_W-1:0]  set_frames  [DEF_PROCESSES];

   page_rsp_type pending_results[$];
   int           error_count    = 0;
   int           send_idle_pct  = 0;
   int           rsp_stall_pct  = 0;

   function automatic page_rsp_type predict_replacer(input page_req_type r);
      page_rsp_type res;
      int           p, n, h, pick, k, sweep_round, i;
      bit           found;
      p = r.proc_id;
      res.victim_page  = '0;
      res.victim_dirty = 1'b0;
      res.status       = ST_OK;
      case (r.operation)
         OP_INIT: begin
            n = (r.set_size > SET_LIMIT) ? SET_LIMIT : r.set_size;
            for (i = 0; i < DEF_PAGES; i++) map_valid[p][i] = 1'b0;
            for (i = 0; i < n; i++) begin
               frame_page[p][i]  = PAGE_W'(i);
               frame_used[p][i]  = 1'b0;
               frame_dirty[p][i] = 1'b0;
               map_valid[p][i]   = 1'b1;
               map_frame[p][i]   = FRAME_IDX_W'(i);
            end
            set_frames[p] = SET_SIZE_W'(n);
            clock_pos[p]  = '0;
         end
         OP_TOUCH: begin
            if (!map_valid[p][r.page]) begin
               res.status = ST_MISS;
            end else begin
               frame_used[p][map_frame[p][r.page]]  = 1'b1;
               frame_dirty[p][map_frame[p][r.page]] = r.dirty_in;
            end
         end
         OP_REPLACE: begin
            n = set_frames[p];
            if (n == 0) begin
               res.status = ST_EMPTY;
            end else begin
               h     = clock_pos[p] % n;
               found = 1'b0;
               pick  = 0;
               for (sweep_round = 0; sweep_round < 2 && !found; sweep_round++) begin
                  // unused clean first
                  for (k = 0; k < n && !found; k++) begin
                     if (!frame_used[p][h] && !frame_dirty[p][h]) begin
                        found = 1'b1;
                        pick  = h;
                     end
                     h = (h + 1) % n;
                  end
                  // then unused dirty, clearing used bits on the way
                  for (k = 0; k < n && !found; k++) begin
                     if (!frame_used[p][h] && frame_dirty[p][h]) begin
                        found = 1'b1;
                        pick  = h;
                     end else begin
                        frame_used[p][h] = 1'b0;
                     end
                     h = (h + 1) % n;
                  end
               end
               clock_pos[p]     = FRAME_IDX_W'(h);
               res.victim_page  = frame_page[p][pick];
               res.victim_dirty = frame_dirty[p][pick];
               if (map_valid[p][res.victim_page] && map_frame[p][res.victim_page] == pick)
                  map_valid[p][res.victim_page] = 1'b0;
               frame_page[p][pick]  = r.page;
               frame_used[p][pick]  = 1'b1;
               frame_dirty[p][pick] = 1'b0;
               map_valid[p][r.page] = 1'b1;
               map_frame[p][r.page] = FRAME_IDX_W'(pick);
            end
         end
         default: ;
      endcase
      return res;
   endfunction

   function automatic page_req_type make_request(input logic [OPERATION_W-1:0] op,
                                                 input int p, input int page,
                                                 input bit dirty, input int size);
      page_req_type r;
      r.operation = op;
      r.proc_id   = PROCESS_W'(p);
      r.page      = PAGE_W'(page);
      r.dirty_in  = dirty;
      r.set_size  = SET_SIZE_W'(size);
      return r;
   endfunction

   // Mostly touches, largely of resident pages, and replaces, with the odd re-init and unused operation
   function automatic page_req_type random_request();
      page_req_type r;
      int           roll, n;
      r.operation = OPERATION_W'($urandom_range(3));
      r.proc_id   = PROCESS_W'($urandom_range(DEF_PROCESSES - 1));
      r.page      = PAGE_W'($urandom_range(DEF_PAGES - 1));
      r.dirty_in  = 1'($urandom_range(1));
      r.set_size  = SET_SIZE_W'($urandom_range(31));
      n           = set_frames[r.proc_id];
      roll        = $urandom_range(99);
      if (roll < 10) begin
         r.operation = OP_INIT;
         roll = $urandom_range(99);
         if (roll < 50)
            r.set_size = SET_SIZE_W'($urandom_range(4, 1));
         else if (roll < 85)
            r.set_size = SET_SIZE_W'($urandom_range(DEF_FRAMES, 5));
      end else if (roll < 55) begin
         r.operation = OP_TOUCH;
         if (n != 0 && $urandom_range(3) != 0)
            r.page = frame_page[r.proc_id][$urandom_range(n - 1)];
      end else if (roll < 96) begin
         r.operation = OP_REPLACE;
         if (n != 0 && $urandom_range(3) == 0)
            r.page = frame_page[r.proc_id][$urandom_range(n - 1)];
      end else begin
         r.operation = OP_UNUSED;
      end
      return r;
   endfunction

   // Entered after a rising edge; leaves at the edge where the request is taken
   task automatic send_request(input page_req_type r);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(negedge clock);
      end
      req_bus.valid     <= 1'b1;
      req_bus.operation <= r.operation;
      req_bus.process   <= r.proc_id;
      req_bus.page      <= r.page;
      req_bus.dirty_in  <= r.dirty_in;
      req_bus.set_size  <= r.set_size;
      @(posedge clock);
      while (req_bus.ready !== 1'b1) @(posedge clock);
      pending_results.push_back(predict_replacer(r));
   endtask

   task automatic report_mismatch(input string field, input logic [7:0] want,
                                  input logic [7:0] got);
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
      error_count++;
   endtask

   always @(posedge clock) begin : check_results
      page_rsp_type want;
      if (reset === 1'b0 && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
         if (pending_results.size() == 0) begin
            $display("%0t: unexpected result, actual page %0d dirty %0d status %0d",
                     $time, rsp_bus.victim_page, rsp_bus.victim_dirty, rsp_bus.status);
            error_count++;
         end else begin
            want = pending_results.pop_front();
            if (rsp_bus.victim_page !== want.victim_page)
               report_mismatch("victim_page", 8'(want.victim_page),
                               8'(rsp_bus.victim_page));
            if (rsp_bus.victim_dirty !== want.victim_dirty)
               report_mismatch("victim_dirty", 8'(want.victim_dirty),
                               8'(rsp_bus.victim_dirty));
            if (rsp_bus.status !== want.status)
               report_mismatch("status", 8'(want.status), 8'(rsp_bus.status));
         end
      end
   end

   initial begin
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         rsp_bus.ready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   task automatic test_init_extremes();
      send_request(make_request(OP_INIT, 0, 0, 1'b0, 0));
      send_request(make_request(OP_REPLACE, 0, 5, 1'b0, 0));
      send_request(make_request(OP_TOUCH, 0, 0, 1'b1, 0));
      send_request(make_request(OP_INIT, 1, 63, 1'b1, 31));   // saturates to full set
      send_request(make_request(OP_INIT, 2, 0, 1'b0, DEF_FRAMES));
      send_request(make_request(OP_INIT, 3, 0, 1'b0, 1));
      send_request(make_request(OP_INIT, 0, 0, 1'b0, DEF_FRAMES + 1));
   endtask

   task automatic test_touch_cases();
      send_request(make_request(OP_TOUCH, 1, 15, 1'b1, 0));
      send_request(make_request(OP_TOUCH, 1, 16, 1'b0, 0));
      send_request(make_request(OP_TOUCH, 1, 63, 1'b1, 31));
      send_request(make_request(OP_TOUCH, 1, 0, 1'b0, 0));
      send_request(make_request(OP_TOUCH, 3, 0, 1'b1, 0));
   endtask

   task automatic test_replace_cases();
      // single frame, used and dirty: both rounds needed
      send_request(make_request(OP_REPLACE, 3, 63, 1'b0, 0));
      // page already resident is loaded again
      send_request(make_request(OP_REPLACE, 3, 63, 1'b0, 0));
      send_request(make_request(OP_REPLACE, 1, 40, 1'b0, 0));
      send_request(make_request(OP_REPLACE, 1, 40, 1'b1, 0));
      send_request(make_request(OP_TOUCH, 1, 40, 1'b1, 0));
      send_request(make_request(OP_REPLACE, 2, 0, 1'b0, 0));
      send_request(make_request(OP_TOUCH, 2, 1, 1'b1, 0));
      send_request(make_request(OP_REPLACE, 2, 33, 1'b0, 0));
   endtask

   task automatic test_unknown_operation();
      send_request(make_request(OP_UNUSED, 3, 63, 1'b1, 31));
      send_request(make_request(OP_TOUCH, 3, 63, 1'b0, 0));
   endtask

   task automatic test_random_traffic(input int sender_idle, input int receiver_stall,
                                      input int count);
      send_idle_pct = sender_idle;
      rsp_stall_pct = receiver_stall;
      repeat (count) send_request(random_request());
   endtask

   task automatic drain_results();
      @(negedge clock);
      req_bus.valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
   endtask

   initial begin
      reset             = 1'b1;
      req_bus.valid     = 1'b0;
      req_bus.operation = OP_INIT;
      req_bus.process   = '0;
      req_bus.page      = '0;
      req_bus.dirty_in  = 1'b0;
      req_bus.set_size  = '0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_init_extremes();
      test_touch_cases();
      test_replace_cases();
      test_unknown_operation();
      test_random_traffic(0, 0, 275);
      test_random_traffic(62, 0, 275);
      test_random_traffic(0, 62, 275);
      test_random_traffic(12, 12, 275);
      drain_results();

      if (error_count == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

   initial begin
      #5_000_000;
      $display("timeout with %0d results outstanding", pending_results.size());
      $display("*** FAILED ***");
      $finish;
   end

endmodule
